/* src/isa_pkg.sv */
// shared types and constants for the indexed shift array
package isa_pkg;

  localparam int FUNC_W = 3;

  typedef enum logic [FUNC_W-1:0] {
    FN_READ_LAST   = 3'd0,
    FN_READ_AT     = 3'd1,
    FN_REMOVE_LAST = 3'd2,
    FN_REMOVE_AT   = 3'd3,
    FN_APPEND      = 3'd4,
    FN_INSERT_AT   = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    OP_HOLD       = 2'd0,
    OP_WRITE      = 2'd1,
    OP_SHIFT_DOWN = 2'd2,
    OP_SHIFT_UP   = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     err;
    logic     read_en;
  } ctrl_t;

endpackage

/* src/isa_cell_array.sv */
// row of storage cells with per-cell shift, write and a single read port
module isa_cell_array #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32,
  parameter int ADDR_W     = 4
) (
  input  logic                  clk,
  input  isa_pkg::cell_op_t     op,
  input  logic [ADDR_W-1:0]     pos,
  input  logic [DATA_WIDTH-1:0] wr_data,
  output logic [DATA_WIDTH-1:0] rd_data
);

  logic [DATA_WIDTH-1:0] cells_r [CAPACITY];

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [DATA_WIDTH-1:0] upper;
    logic [DATA_WIDTH-1:0] lower;
    logic [DATA_WIDTH-1:0] cell_nxt;

    if (k < CAPACITY - 1) begin : g_up
      assign upper = cells_r[k+1];
    end else begin : g_top
      assign upper = cells_r[k];
    end

    if (k > 0) begin : g_lo
      assign lower = cells_r[k-1];
    end else begin : g_bot
      assign lower = cells_r[k];
    end

    always_comb begin
      cell_nxt = cells_r[k];
      case (op)
        isa_pkg::OP_WRITE: begin
          if (ADDR_W'(k) == pos) cell_nxt = wr_data;
        end
        isa_pkg::OP_SHIFT_DOWN: begin
          if (ADDR_W'(k) >= pos) cell_nxt = upper;
        end
        isa_pkg::OP_SHIFT_UP: begin
          if (ADDR_W'(k) == pos) cell_nxt = wr_data;
          else if (ADDR_W'(k) > pos) cell_nxt = lower;
        end
        default: cell_nxt = cells_r[k];
      endcase
    end

    always_ff @(posedge clk) begin
      cells_r[k] <= cell_nxt;
    end
  end

  assign rd_data = cells_r[pos];

endmodule

/* src/isa_ctrl.sv */
// request decode, range checks and fill count register
module isa_ctrl #(
  parameter int CAPACITY = 16,
  parameter int LEN_W    = 5,
  parameter int ADDR_W   = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      item_vld,
  input  logic [isa_pkg::FUNC_W-1:0] func,
  input  logic [LEN_W-1:0]          index,
  output isa_pkg::ctrl_t            ctrl,
  output logic [ADDR_W-1:0]         pos,
  output logic [LEN_W-1:0]          length_nxt
);

  localparam int CMP_W = LEN_W;

  logic [LEN_W-1:0] length_r;
  logic [CMP_W-1:0] idx_c;
  logic [CMP_W-1:0] len_c;
  logic             empty;
  logic             full;
  isa_pkg::cell_op_t op_raw;
  logic             err;
  logic             read_en;
  logic [CMP_W-1:0] pos_c;
  logic [LEN_W-1:0] len_upd;

  assign idx_c = CMP_W'(index);
  assign len_c = CMP_W'(length_r);
  assign empty = (length_r == '0);
  assign full  = (length_r == LEN_W'(CAPACITY));

  always_comb begin
    err     = 1'b0;
    read_en = 1'b0;
    op_raw  = isa_pkg::OP_HOLD;
    pos_c   = idx_c;
    len_upd = length_r;
    case (func)
      isa_pkg::FN_READ_LAST: begin
        err     = empty;
        read_en = 1'b1;
        pos_c   = len_c - CMP_W'(1);
      end
      isa_pkg::FN_READ_AT: begin
        err     = (idx_c >= len_c);
        read_en = 1'b1;
      end
      isa_pkg::FN_REMOVE_LAST: begin
        err     = empty;
        len_upd = length_r - LEN_W'(1);
      end
      isa_pkg::FN_REMOVE_AT: begin
        err     = (idx_c >= len_c);
        op_raw  = isa_pkg::OP_SHIFT_DOWN;
        len_upd = length_r - LEN_W'(1);
      end
      isa_pkg::FN_APPEND: begin
        err     = full;
        op_raw  = isa_pkg::OP_WRITE;
        pos_c   = len_c;
        len_upd = length_r + LEN_W'(1);
      end
      isa_pkg::FN_INSERT_AT: begin
        err     = full || (idx_c > len_c);
        op_raw  = isa_pkg::OP_SHIFT_UP;
        len_upd = length_r + LEN_W'(1);
      end
      default: err = 1'b1;
    endcase
  end

  // errors and empty slots leave cells and count untouched
  assign ctrl.err     = err;
  assign ctrl.read_en = read_en && !err;
  assign ctrl.op      = (item_vld && !err) ? op_raw : isa_pkg::OP_HOLD;
  assign pos          = ADDR_W'(pos_c);
  assign length_nxt   = (item_vld && !err) ? len_upd : length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_r <= '0;
    end else begin
      length_r <= length_nxt;
    end
  end

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    length_r <= LEN_W'(CAPACITY))
    else $error("fill count above capacity");

  a_len_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !($past(item_vld) && !$past(err)) |-> $stable(length_r))
    else $error("fill count moved without a successful request");
`endif

endmodule

/* src/indexed_shift_array_unit.sv */
// Indexed shift array: an ordered array of up to CAPACITY signed words with a
// fill count. Each request (in_func, in_index, in_value) is taken at an edge
// where start is high and busy is low; busy never rises, so a request may come
// every cycle. Every request gives one result through the request register and
// then the result register, marked by out_valid for one cycle, in request
// order: out_status (0 ok, 1 bad index, empty, full or unknown function),
// out_read_data (zero unless a read succeeds) and out_fill_count after the
// request. The rate is one request per cycle, set by the single decode and
// shift stage between the request register and the result register; all
// cells shift in parallel in that stage. The result port cannot be held off.
// Cells have no reset and only entries below the fill count are ever read.
module indexed_shift_array_unit #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [isa_pkg::FUNC_W-1:0]          in_func,
  input  logic [$clog2(CAPACITY + 1)-1:0]     in_index,
  input  logic signed [DATA_WIDTH-1:0]        in_value,
  output logic                                out_valid,
  output logic                                out_status,
  output logic signed [DATA_WIDTH-1:0]        out_read_data,
  output logic [$clog2(CAPACITY + 1)-1:0]     out_fill_count
);

  localparam int LEN_W  = $clog2(CAPACITY + 1);
  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic                        item_vld_r;
  logic [isa_pkg::FUNC_W-1:0]  func_r;
  logic [LEN_W-1:0]            index_r;
  logic [DATA_WIDTH-1:0]       value_r;

  isa_pkg::ctrl_t              ctrl;
  logic [ADDR_W-1:0]           pos;
  logic [LEN_W-1:0]            length_nxt;
  logic [DATA_WIDTH-1:0]       rd_data;

  logic                        out_valid_r;
  logic                        status_r;
  logic [DATA_WIDTH-1:0]       read_data_r;
  logic [LEN_W-1:0]            fill_r;

  assign busy = 1'b0;

  // request beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else begin
      item_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      func_r  <= in_func;
      index_r <= in_index;
      value_r <= in_value;
    end
  end

  isa_ctrl #(
    .CAPACITY (CAPACITY),
    .LEN_W    (LEN_W),
    .ADDR_W   (ADDR_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_vld   (item_vld_r),
    .func       (func_r),
    .index      (index_r),
    .ctrl       (ctrl),
    .pos        (pos),
    .length_nxt (length_nxt)
  );

  isa_cell_array #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH),
    .ADDR_W     (ADDR_W)
  ) u_cells (
    .clk     (clk),
    .op      (ctrl.op),
    .pos     (pos),
    .wr_data (value_r),
    .rd_data (rd_data)
  );

  // result beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= item_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (item_vld_r) begin
      status_r    <= ctrl.err;
      read_data_r <= ctrl.read_en ? rd_data : '0;
      fill_r      <= length_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_read_data  = read_data_r;
  assign out_fill_count = fill_r;

`ifndef SYNTHESIS
  a_two_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 2))
    else $error("result beat without a request two cycles earlier");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_read_data == '0)
    else $error("error result carries read data");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_fill_count) <= 32'(CAPACITY))
    else $error("reported fill count above capacity");
`endif

endmodule
